// File: sv/rate_monotonic_tick_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rate-monotonic tick scheduler
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_MACROS_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_MACROS_SVH

// Property checked at every edge out of reset.
`define RMTS_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RMTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared constants and types of the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmts_pkg;

  localparam int MAX_TASKS_DEF  = 8;
  localparam int TICK_WIDTH_DEF = 8;

  localparam int COUNT_W   = 4;  // task_count and running_task
  localparam int SLOT_W    = 3;
  localparam int IN_TICK_W = 8;  // exec_ticks and period_ticks

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Operations the sequencer issues to the task table in one cycle
  typedef struct packed {
    logic load;  // write all four fields of the load slot
    logic scan;  // count down / release the entry at the table address
    logic dec;   // take one tick of budget from the entry at the table address
  } tbl_ctrl_t;

endpackage

// File: sv/rate_monotonic_tick_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// Periodic task table with rate-monotonic selection, one word per tick.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets task_count, the number
//   of slots in use from slot zero; cfg_ready is always high. Write it only
//   while no item is in flight.
//   in channel carries one item: kind 0 loads a slot (budget, period; a
//   period of 0 counts as 1) and gives no result; kind 1 is a tick.
//   out channel carries one word per tick: running_task (slot + 1, 0 when
//   idle) and idle.
// Timing: a load is written to the table in the cycle it is accepted. A
//   tick scans the used slots, where used = min(task_count, MAX_TASKS):
//   the shared period compare visits one slot per cycle, releasing it as
//   it goes; then the DEC state charges the winner unless it was released
//   in this tick, and the EMIT state loads the output register. With no
//   slot in use a tick goes straight to EMIT. in_ready stays low until the
//   word is loaded, so a new item is not taken while a tick is in flight.
// Reset clears task_count, remaining budgets and countdowns at once.
// If the receiver stalls, the result word holds in the output register; a
//   following tick completes its scan and then waits until the word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rate_monotonic_tick_scheduler_macros.svh"

module rate_monotonic_tick_scheduler #(
  parameter int MAX_TASKS  = rmts_pkg::MAX_TASKS_DEF,
  parameter int TICK_WIDTH = rmts_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmts_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [rmts_pkg::SLOT_W-1:0]    slot,
  input  logic [rmts_pkg::IN_TICK_W-1:0] exec_ticks,
  input  logic [rmts_pkg::IN_TICK_W-1:0] period_ticks,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rmts_pkg::COUNT_W-1:0]   running_task,
  output logic                           idle
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int SAT_W = (TICK_WIDTH > rmts_pkg::IN_TICK_W) ? TICK_WIDTH
                                                            : rmts_pkg::IN_TICK_W;
  localparam logic [SAT_W-1:0] TICK_MAX = SAT_W'({TICK_WIDTH{1'b1}});

  logic [rmts_pkg::COUNT_W-1:0] task_count;

  logic                  accept;
  logic                  load_req;
  logic                  start;
  logic [4:0]            tc_ext;
  logic [4:0]            used_ext;
  logic [CNT_W-1:0]      used;
  logic [4:0]            slot_ext;
  logic [IDX_W-1:0]      load_idx;
  logic [SAT_W-1:0]      budget_ext;
  logic [SAT_W-1:0]      period_ext;
  logic [SAT_W-1:0]      budget_sat;
  logic [SAT_W-1:0]      period_sat;
  logic [TICK_WIDTH-1:0] load_budget;
  logic [TICK_WIDTH-1:0] load_period;

  rmts_pkg::tbl_ctrl_t   ctrl;
  logic [IDX_W-1:0]      addr;
  logic [TICK_WIDTH-1:0] rd_remaining;
  logic [TICK_WIDTH-1:0] rd_period;
  logic                  rd_due;
  logic                  busy;
  logic                  emit;
  logic                  emit_ok;
  logic                  found;
  logic [IDX_W-1:0]      best;
  logic [4:0]            task_num;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      task_count <= cfg_data;
    end
  end

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign start    = accept && (kind == rmts_pkg::KIND_TICK);

  // Drop loads aimed past the table
  assign slot_ext = 5'(slot);
  assign load_idx = slot_ext[IDX_W-1:0];
  assign load_req = accept && (kind == rmts_pkg::KIND_LOAD)
                    && (32'(slot) < MAX_TASKS);

  // Clamp the slot count to the table depth
  assign tc_ext   = 5'(task_count);
  assign used_ext = (tc_ext > 5'(MAX_TASKS)) ? 5'(MAX_TASKS) : tc_ext;
  assign used     = used_ext[CNT_W-1:0];

  // Saturate load fields to the tick width; a zero period becomes one
  assign budget_ext  = SAT_W'(exec_ticks);
  assign period_ext  = SAT_W'(period_ticks);
  assign budget_sat  = (budget_ext > TICK_MAX) ? TICK_MAX : budget_ext;
  assign period_sat  = (period_ext > TICK_MAX) ? TICK_MAX : period_ext;
  assign load_budget = budget_sat[TICK_WIDTH-1:0];
  assign load_period = (period_sat == '0) ? TICK_WIDTH'(1) : period_sat[TICK_WIDTH-1:0];

  rmts_task_table #(
    .MAX_TASKS  (MAX_TASKS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .load_idx     (load_idx),
    .load_budget  (load_budget),
    .load_period  (load_period),
    .addr         (addr),
    .rd_remaining (rd_remaining),
    .rd_period    (rd_period),
    .rd_due       (rd_due)
  );

  rmts_seq #(
    .MAX_TASKS  (MAX_TASKS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .load_req     (load_req),
    .used         (used),
    .emit_ok      (emit_ok),
    .rd_remaining (rd_remaining),
    .rd_period    (rd_period),
    .rd_due       (rd_due),
    .ctrl         (ctrl),
    .addr         (addr),
    .busy         (busy),
    .emit         (emit),
    .found        (found),
    .best         (best)
  );

  // Output register: load the word once the previous one is gone
  assign emit_ok  = emit && (!out_valid || out_ready);
  assign task_num = 5'(best) + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      running_task <= found ? task_num[rmts_pkg::COUNT_W-1:0] : '0;
      idle         <= !found;
    end
  end

  `RMTS_ASSERT_PROP(a_idle_matches_task, !out_valid || (idle == (running_task == '0)), "idle flag disagrees with running_task")
  `RMTS_ASSERT_NEXT(a_tick_holds_input, start, !in_ready, "input taken again right after a tick")
  `RMTS_ASSERT_PROP(a_task_in_range, !out_valid || idle || (32'(running_task) <= MAX_TASKS) || (MAX_TASKS > 15), "running_task beyond the table")

endmodule

// File: sv/rmts_task_table.sv
// ----------------------------------------------------------------------------
// rmts_task_table
// Per-slot budget, period, remaining budget and release countdown, with one
// shared read/update port at the address the sequencer drives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmts_task_table #(
  parameter int MAX_TASKS  = rmts_pkg::MAX_TASKS_DEF,
  parameter int TICK_WIDTH = rmts_pkg::TICK_WIDTH_DEF,
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rmts_pkg::tbl_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]      load_idx,
  input  logic [TICK_WIDTH-1:0] load_budget,
  input  logic [TICK_WIDTH-1:0] load_period,
  input  logic [IDX_W-1:0]      addr,
  output logic [TICK_WIDTH-1:0] rd_remaining,
  output logic [TICK_WIDTH-1:0] rd_period,
  output logic                  rd_due
);

  logic [TICK_WIDTH-1:0] budget_table    [MAX_TASKS];
  logic [TICK_WIDTH-1:0] period_table    [MAX_TASKS];
  logic [TICK_WIDTH-1:0] remaining_table [MAX_TASKS];
  logic [TICK_WIDTH-1:0] countdown       [MAX_TASKS];

  logic [TICK_WIDTH-1:0] cd_cur;

  assign cd_cur       = countdown[addr];
  assign rd_remaining = remaining_table[addr];
  assign rd_period    = period_table[addr];
  assign rd_due       = (cd_cur <= TICK_WIDTH'(1));

  // Budget and period hold no reset; they are valid once loaded.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      budget_table[load_idx] <= load_budget;
      period_table[load_idx] <= load_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        remaining_table[i] <= '0;
        countdown[i]       <= '0;
      end
    end else if (ctrl.load) begin
      remaining_table[load_idx] <= load_budget;
      countdown[load_idx]       <= load_period;
    end else if (ctrl.scan) begin
      // Release at the period boundary: refill budget, restart countdown
      if (rd_due) begin
        remaining_table[addr] <= budget_table[addr];
        countdown[addr]       <= period_table[addr];
      end else begin
        countdown[addr] <= cd_cur - TICK_WIDTH'(1);
      end
    end else if (ctrl.dec) begin
      remaining_table[addr] <= rd_remaining - TICK_WIDTH'(1);
    end
  end

endmodule

// File: sv/rmts_seq.sv
// ----------------------------------------------------------------------------
// rmts_seq
// Tick sequencer: walks the slots in use through one shared period compare,
// releasing each slot as it goes, then charges the winner one tick unless it was just released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmts_seq #(
  parameter int MAX_TASKS  = rmts_pkg::MAX_TASKS_DEF,
  parameter int TICK_WIDTH = rmts_pkg::TICK_WIDTH_DEF,
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CNT_W     = $clog2(MAX_TASKS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  load_req,
  input  logic [CNT_W-1:0]      used,
  input  logic                  emit_ok,
  input  logic [TICK_WIDTH-1:0] rd_remaining,
  input  logic [TICK_WIDTH-1:0] rd_period,
  input  logic                  rd_due,
  output rmts_pkg::tbl_ctrl_t   ctrl,
  output logic [IDX_W-1:0]      addr,
  output logic                  busy,
  output logic                  emit,
  output logic                  found,
  output logic [IDX_W-1:0]      best
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state;
  logic [IDX_W-1:0]      idx;
  logic [TICK_WIDTH-1:0] best_period;
  logic                  best_due;
  logic                  take;
  logic                  last;

  // Shared compare: strictly shorter period wins, so the lower slot keeps ties
  assign take = (rd_remaining != '0) && (!found || (rd_period < best_period));
  assign last = (CNT_W'(idx) == (used - CNT_W'(1)));

  assign busy = (state != ST_IDLE);
  assign emit = (state == ST_EMIT);
  assign addr = (state == ST_DEC) ? best : idx;

  always_comb begin
    ctrl      = '0;
    ctrl.load = load_req;
    ctrl.scan = (state == ST_SCAN);
    // A winner released this tick has its budget refilled; skip the charge
    ctrl.dec  = (state == ST_DEC) && found && !best_due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            found <= 1'b0;
            state <= (used == '0) ? ST_EMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (take) begin
            found <= 1'b1;
          end
          if (last) begin
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      idx <= '0;
    end else if (state == ST_SCAN) begin
      idx <= idx + IDX_W'(1);
      if (take) begin
        best        <= idx;
        best_period <= rd_period;
        best_due    <= rd_due;
      end
    end
  end

endmodule
